>>> rtl/core/rcic_pkg.sv
// Shared types and codes of the reference-counted item cache.
package rcic_pkg;

   localparam int KEY_BITS   = 64;
   localparam int HOUT_BITS  = 32;
   localparam int REFS_BITS  = 16;

   localparam logic [1:0] CMD_ACQUIRE = 2'd0;
   localparam logic [1:0] CMD_FILL    = 2'd1;
   localparam logic [1:0] CMD_RELEASE = 2'd2;

   localparam logic [REFS_BITS-1:0] REFS_MAX = '1;

   typedef enum logic [2:0] {
      STAT_HIT     = 3'd0,
      STAT_MISS    = 3'd1,
      STAT_BUSY    = 3'd2,
      STAT_FULL    = 3'd3,
      STAT_FILLED  = 3'd4,
      STAT_KEPT    = 3'd5,
      STAT_EVICTED = 3'd6,
      STAT_ERROR   = 3'd7
   } status_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [1:0]           command;
      logic [KEY_BITS-1:0]  key;
      logic [HOUT_BITS-1:0] fill_handle;
   } req_type;

   typedef struct packed {
      status_type           status;
      logic [HOUT_BITS-1:0] handle;
      logic [REFS_BITS-1:0] ref_count;
   } rsp_type;

endpackage

>>> rtl/core/refcount_item_cache_unit.sv
// Reference-counted item cache: entry table, key search sequencer and response register.
//
// The cache holds up to CAPACITY items, each keyed by a 64-bit identifier with a
// handle, a 16-bit saturating reference count and a loading mark. A request is
// acquire, fill or release; every request yields exactly one response. All
// entries live in a single-port-write, single-port-read table; one 64-bit key
// comparator walks the table one entry per cycle. A request passes through
// the reads of all CAPACITY entries, the compare of the last entry read, the
// close of the walk, the table update and the load of the response register,
// which waits while an earlier response is still not taken; the next request
// is taken only after that load. The response register lets the next request
// enter while an earlier response still waits.
// After reset the table is swept once to mark every entry free, and req_ready
// stays low during the sweep; csr writes are taken at any time. The effective
// entry limit is the smaller of max_entries and CAPACITY; lowering it keeps
// existing entries and only blocks new reservations.
module refcount_item_cache_unit #(
   parameter int CAPACITY    = 64,
   parameter int HANDLE_BITS = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  rcic_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rcic_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [6:0]       csr_wdata
);
   import rcic_pkg::*;

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CNT_W > 7) ? CNT_W : 7;
   localparam logic [CNT_W-1:0] CNT_CAP  = CNT_W'(CAPACITY);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CAPACITY - 1);

   typedef struct packed {
      logic                   used;
      logic                   loading;
      logic [KEY_BITS-1:0]    key;
      logic [HANDLE_BITS-1:0] handle;
      logic [REFS_BITS-1:0]   refs;
   } entry_type;

   // entry table
   entry_type entry_mem [CAPACITY];
   entry_type mem_rd_ff;
   logic              mem_we;
   logic [IDX_W-1:0]  mem_waddr;
   entry_type         mem_wdata;

   // sequencer
   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  scan_idx_ff, scan_idx_in;
   logic              rd_pend_ff, rd_pend_in;
   logic [IDX_W-1:0]  rd_idx_ff;
   logic              issue;

   // request and search results
   req_type           req_ff;
   logic              hit_ff, hit_in;
   logic [IDX_W-1:0]  hit_idx_ff, hit_idx_in;
   entry_type         hit_ent_ff, hit_ent_in;
   logic              free_ff, free_in;
   logic [IDX_W-1:0]  free_idx_ff, free_idx_in;

   // bookkeeping and response
   logic [CNT_W-1:0]  occ_ff, occ_in;
   logic [6:0]        max_entries_ff;
   rsp_type           res_ff, res_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff;

   logic              accept;
   logic              scan_done;
   logic              at_limit;
   logic [CMP_W-1:0]  limit;
   logic [63:0]       hit_h64;
   logic [63:0]       fill_h64;
   logic [HANDLE_BITS-1:0] fill_h;

   assign accept    = req_valid && req_ready;
   assign issue     = (state_ff == ST_SCAN) && (scan_idx_ff != CNT_CAP);
   assign scan_done = (scan_idx_ff == CNT_CAP) && !rd_pend_ff;

   // effective limit is min(max_entries, CAPACITY)
   assign limit    = (CMP_W'(max_entries_ff) < CMP_W'(CAPACITY)) ?
                     CMP_W'(max_entries_ff) : CMP_W'(CAPACITY);
   assign at_limit = CMP_W'(occ_ff) >= limit;

   // handles are kept at HANDLE_BITS; the response shows the low 32 bits
   assign fill_h64 = {32'd0, req_ff.fill_handle};
   assign fill_h   = fill_h64[HANDLE_BITS-1:0];
   assign hit_h64  = 64'(hit_ent_ff.handle);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (scan_idx_ff == CNT_LAST) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (scan_done) state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // search: compare the entry read last cycle, remember first match and first free slot
   always_comb begin
      hit_in      = hit_ff;
      hit_idx_in  = hit_idx_ff;
      hit_ent_in  = hit_ent_ff;
      free_in     = free_ff;
      free_idx_in = free_idx_ff;
      if (accept) begin
         hit_in  = 1'b0;
         free_in = 1'b0;
      end else if ((state_ff == ST_SCAN) && rd_pend_ff) begin
         if (mem_rd_ff.used && (mem_rd_ff.key == req_ff.key) && !hit_ff) begin
            hit_in     = 1'b1;
            hit_idx_in = rd_idx_ff;
            hit_ent_in = mem_rd_ff;
         end
         if (!mem_rd_ff.used && !free_ff) begin
            free_in     = 1'b1;
            free_idx_in = rd_idx_ff;
         end
      end
   end

   // outputs of the sequencer: table writes, counters, result
   always_comb begin
      req_ready    = (state_ff == ST_IDLE);
      mem_we       = 1'b0;
      mem_waddr    = hit_idx_ff;
      mem_wdata    = hit_ent_ff;
      occ_in       = occ_ff;
      res_in       = res_ff;
      scan_idx_in  = scan_idx_ff;
      rd_pend_in   = issue;
      rsp_valid_in = rsp_valid_ff;

      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;

      case (state_ff)
         ST_CLEAR: begin
            // sweep: mark every entry free
            mem_we      = 1'b1;
            mem_waddr   = scan_idx_ff[IDX_W-1:0];
            mem_wdata   = '0;
            scan_idx_in = scan_idx_ff + CNT_W'(1);
         end
         ST_IDLE: begin
            scan_idx_in = '0;
         end
         ST_SCAN: begin
            if (issue) scan_idx_in = scan_idx_ff + CNT_W'(1);
         end
         ST_DECIDE: begin
            res_in.status    = STAT_ERROR;
            res_in.handle    = '0;
            res_in.ref_count = '0;
            case (req_ff.command)
               CMD_ACQUIRE: begin
                  if (hit_ff && hit_ent_ff.loading) begin
                     res_in.status = STAT_BUSY;
                  end else if (hit_ff) begin
                     mem_we = 1'b1;
                     if (hit_ent_ff.refs != REFS_MAX)
                        mem_wdata.refs = hit_ent_ff.refs + REFS_BITS'(1);
                     res_in.status    = STAT_HIT;
                     res_in.handle    = hit_h64[HOUT_BITS-1:0];
                     res_in.ref_count = mem_wdata.refs;
                  end else if (at_limit || !free_ff) begin
                     res_in.status = STAT_FULL;
                  end else begin
                     // reserve the lowest free entry as loading
                     mem_we            = 1'b1;
                     mem_waddr         = free_idx_ff;
                     mem_wdata.used    = 1'b1;
                     mem_wdata.loading = 1'b1;
                     mem_wdata.key     = req_ff.key;
                     mem_wdata.handle  = '0;
                     mem_wdata.refs    = '0;
                     occ_in            = occ_ff + CNT_W'(1);
                     res_in.status     = STAT_MISS;
                  end
               end
               CMD_FILL: begin
                  if (hit_ff && hit_ent_ff.loading) begin
                     mem_we            = 1'b1;
                     mem_wdata.loading = 1'b0;
                     mem_wdata.handle  = fill_h;
                     mem_wdata.refs    = REFS_BITS'(1);
                     res_in.status     = STAT_FILLED;
                     res_in.handle     = fill_h64[HOUT_BITS-1:0] &
                                         HOUT_BITS'(64'(fill_h));
                     res_in.ref_count  = REFS_BITS'(1);
                  end
               end
               CMD_RELEASE: begin
                  if (hit_ff && !hit_ent_ff.loading) begin
                     mem_we = 1'b1;
                     if (hit_ent_ff.refs > REFS_BITS'(1)) begin
                        mem_wdata.refs   = hit_ent_ff.refs - REFS_BITS'(1);
                        res_in.status    = STAT_KEPT;
                        res_in.ref_count = mem_wdata.refs;
                     end else begin
                        // count hits zero: evict and hand the handle back
                        mem_wdata.used    = 1'b0;
                        mem_wdata.loading = 1'b0;
                        mem_wdata.refs    = '0;
                        if (occ_ff != '0) occ_in = occ_ff - CNT_W'(1);
                        res_in.status = STAT_EVICTED;
                        res_in.handle = hit_h64[HOUT_BITS-1:0];
                     end
                  end
               end
               default: begin
                  res_in.status = STAT_ERROR;
               end
            endcase
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) rsp_valid_in = 1'b1;
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   // entry table: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) entry_mem[mem_waddr] <= mem_wdata;
   end

   always_ff @(posedge clock) begin
      mem_rd_ff <= entry_mem[scan_idx_ff[IDX_W-1:0]];
      rd_idx_ff <= scan_idx_ff[IDX_W-1:0];
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         scan_idx_ff    <= '0;
         rd_pend_ff     <= 1'b0;
         hit_ff         <= 1'b0;
         free_ff        <= 1'b0;
         occ_ff         <= '0;
         max_entries_ff <= 7'd64;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_idx_ff  <= scan_idx_in;
         rd_pend_ff   <= rd_pend_in;
         hit_ff       <= hit_in;
         free_ff      <= free_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) max_entries_ff <= csr_wdata;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) req_ff <= req_data;
      hit_idx_ff  <= hit_idx_in;
      hit_ent_ff  <= hit_ent_in;
      free_idx_ff <= free_idx_in;
      res_ff      <= res_in;
      if ((state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready)) rsp_data_ff <= res_ff;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // occupancy never runs past the table size
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= CNT_CAP)
      else $error("occupancy exceeds capacity");

   // an accepted request always starts a key walk from the first entry
   a_accept_scan: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_SCAN) && (scan_idx_ff == '0))
      else $error("accepted request did not start a search");

   // eviction and kept release only come from a filled, matching entry
   a_release_hit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DECIDE) &&
      ((res_in.status == STAT_EVICTED) || (res_in.status == STAT_KEPT))
      |-> hit_ff && !hit_ent_ff.loading)
      else $error("release result without a filled match");

   // leaving the done state always presents a response
   a_done_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready) |=> rsp_valid_ff)
      else $error("finished request produced no response");

endmodule

>>> verif/testbench.sv
// Self-checking testbench for the reference-counted item cache unit.
module testbench;
   import rcic_pkg::*;

   localparam int CACHE_DEPTH    = 64;
   localparam int HANDLE_WIDTH   = 32;
   localparam int LATENCY        = CACHE_DEPTH + 4;
   localparam int POOL_SIZE      = 80;
   localparam int PHASE_ITEMS    = 204;
   localparam int HOLD_CYCLES    = 400;
   localparam int DRAIN_LIMIT    = 20000;
   localparam int TIMEOUT_CYCLES = 1500000;

   // Command code with no operation behind it; the block must answer error.
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   req_type    req_data = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   rsp_type    rsp_data;
   logic       csr_we = 1'b0;
   logic [6:0] csr_wdata = '0;

   int   send_idle_pct = 0;
   int   recv_stall_pct = 0;
   bit   pressure_go = 1'b0;
   logic rsp_hold = 1'b0;

   logic [63:0] key_pool [POOL_SIZE];

   // Shadow copy of the entry table: predicts the answer to every accepted
   // request and holds the answers still owed by the block.
   class cache_shadow;
      logic [63:0]             ent_key     [CACHE_DEPTH];
      bit                      ent_used    [CACHE_DEPTH];
      bit                      ent_loading [CACHE_DEPTH];
      logic [HANDLE_WIDTH-1:0] ent_handle  [CACHE_DEPTH];
      logic [REFS_BITS-1:0]    ent_refs    [CACHE_DEPTH];
      int unsigned             occupancy;
      logic [6:0]              max_entries;
      rsp_type                 awaited[$];
      int                      errors;
      int                      requests_taken;
      int                      seen [8];

      function new();
         for (int i = 0; i < CACHE_DEPTH; i++) begin
            ent_key[i]     = '0;
            ent_used[i]    = 1'b0;
            ent_loading[i] = 1'b0;
            ent_handle[i]  = '0;
            ent_refs[i]    = '0;
         end
         for (int s = 0; s < 8; s++) seen[s] = 0;
         occupancy      = 0;
         max_entries    = 7'd64;
         errors         = 0;
         requests_taken = 0;
      endfunction

      function int find_entry(logic [63:0] key);
         for (int i = 0; i < CACHE_DEPTH; i++) begin
            if (ent_used[i] && ent_key[i] == key) return i;
         end
         return -1;
      endfunction

      function rsp_type answer(status_type s, logic [HOUT_BITS-1:0] h,
                               logic [REFS_BITS-1:0] c);
         rsp_type a;
         a.status    = s;
         a.handle    = h;
         a.ref_count = c;
         return a;
      endfunction

      // Apply one request to the shadow table and return the answer it earns.
      function rsp_type cache_answer(req_type r);
         int          idx;
         int unsigned lim;
         idx = find_entry(r.key);
         lim = (max_entries < CACHE_DEPTH) ? max_entries : CACHE_DEPTH;
         case (r.command)
            CMD_ACQUIRE: begin
               if (idx >= 0) begin
                  if (ent_loading[idx]) return answer(STAT_BUSY, '0, '0);
                  // saturate the count instead of wrapping
                  if (ent_refs[idx] != REFS_MAX) ent_refs[idx] = ent_refs[idx] + 1'b1;
                  return answer(STAT_HIT, HOUT_BITS'(ent_handle[idx]), ent_refs[idx]);
               end
               if (occupancy >= lim) return answer(STAT_FULL, '0, '0);
               for (int i = 0; i < CACHE_DEPTH; i++) begin
                  if (!ent_used[i]) begin
                     ent_used[i]    = 1'b1;
                     ent_loading[i] = 1'b1;
                     ent_key[i]     = r.key;
                     ent_handle[i]  = '0;
                     ent_refs[i]    = '0;
                     occupancy++;
                     return answer(STAT_MISS, '0, '0);
                  end
               end
               return answer(STAT_FULL, '0, '0);
            end
            CMD_FILL: begin
               if (idx < 0 || !ent_loading[idx]) return answer(STAT_ERROR, '0, '0);
               ent_loading[idx] = 1'b0;
               ent_handle[idx]  = HANDLE_WIDTH'(r.fill_handle);
               ent_refs[idx]    = 16'd1;
               return answer(STAT_FILLED, HOUT_BITS'(ent_handle[idx]), 16'd1);
            end
            CMD_RELEASE: begin
               if (idx < 0 || ent_loading[idx]) return answer(STAT_ERROR, '0, '0);
               if (ent_refs[idx] > 16'd1) begin
                  ent_refs[idx] = ent_refs[idx] - 1'b1;
                  return answer(STAT_KEPT, '0, ent_refs[idx]);
               end
               ent_used[idx]    = 1'b0;
               ent_loading[idx] = 1'b0;
               ent_refs[idx]    = '0;
               if (occupancy > 0) occupancy--;
               return answer(STAT_EVICTED, HOUT_BITS'(ent_handle[idx]), '0);
            end
            default: return answer(STAT_ERROR, '0, '0);
         endcase
      endfunction

      task report(string what);
         if (errors < 100) $display("MISMATCH: %s", what);
         errors++;
      endtask

      function void take_request(req_type r);
         awaited.push_back(cache_answer(r));
         requests_taken++;
      endfunction

      task check_response(rsp_type got);
         rsp_type want;
         if (awaited.size() == 0) begin
            report($sformatf("response status %0d with nothing awaited", got.status));
            return;
         end
         want = awaited.pop_front();
         if (got.status !== want.status)
            report($sformatf("status %0d, want %0d", got.status, want.status));
         if (got.handle !== want.handle)
            report($sformatf("handle %h, want %h (status %0d)",
                             got.handle, want.handle, want.status));
         if (got.ref_count !== want.ref_count)
            report($sformatf("ref_count %0d, want %0d (status %0d)",
                             got.ref_count, want.ref_count, want.status));
         seen[int'(want.status)]++;
      endtask
   endclass

   cache_shadow shadow = new();

   refcount_item_cache_unit #(
      .CAPACITY(CACHE_DEPTH),
      .HANDLE_BITS(HANDLE_WIDTH)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_we(csr_we),
      .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Receiver: check each response taken at this edge, then pick the next
   // ready value. Hold ready low while the long hold-off runs.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) shadow.check_response(rsp_data);
      if (reset || rsp_hold) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Long receiver hold-off, counted here so the sender keeps offering
   // requests until the block backs up and drops req_ready.
   initial begin : hold_off
      wait (pressure_go);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   initial begin : watchdog
      repeat (TIMEOUT_CYCLES) @(posedge clock);
      $display("Timed out waiting on the cache unit");
      $display("RESULT: ERROR");
      $finish;
   end

   function automatic req_type make_req(logic [1:0] cmd, logic [63:0] key,
                                        logic [31:0] fh);
      req_type r;
      r.command     = cmd;
      r.key         = key;
      r.fill_handle = fh;
      return r;
   endfunction

   // Build the next random request. Most traffic follows the life of an entry
   // (acquire, fill, acquire again, release); the rest is noise that must
   // answer busy or error.
   function automatic req_type next_request();
      req_type r;
      int      live[$];
      int      slot;
      int      idx;
      int      roll;
      for (int i = 0; i < POOL_SIZE; i++) begin
         if (shadow.find_entry(key_pool[i]) >= 0) live.push_back(i);
      end
      if (live.size() > 0 && $urandom_range(99) < 55)
         slot = live[$urandom_range(live.size() - 1)];
      else
         slot = $urandom_range(POOL_SIZE - 1);
      idx = shadow.find_entry(key_pool[slot]);
      // Retire an absent key now and then; sometimes use a one-bit neighbor
      // of another key to stress the key compare.
      if (idx < 0 && $urandom_range(99) < 25) begin
         if ($urandom_range(1))
            key_pool[slot] = {$urandom, $urandom};
         else
            key_pool[slot] = key_pool[$urandom_range(POOL_SIZE - 1)]
                             ^ (64'd1 << $urandom_range(63));
         idx = shadow.find_entry(key_pool[slot]);
      end
      r.key         = key_pool[slot];
      r.fill_handle = $urandom;
      roll          = $urandom_range(99);
      if (roll < 4)
         r.command = CMD_UNUSED;
      else if (idx < 0)
         r.command = (roll < 85) ? CMD_ACQUIRE : ((roll < 93) ? CMD_FILL : CMD_RELEASE);
      else if (shadow.ent_loading[idx])
         r.command = (roll < 80) ? CMD_FILL : ((roll < 90) ? CMD_ACQUIRE : CMD_RELEASE);
      else
         r.command = (roll < 48) ? CMD_ACQUIRE : ((roll < 95) ? CMD_RELEASE : CMD_FILL);
      return r;
   endfunction

   // Offer one request and hold it until accepted; note it in the shadow at
   // the accepting edge. Called and returning at a rising edge.
   task automatic send_request(input req_type r);
      int gap;
      gap = 0;
      if (send_idle_pct > 0) begin
         // occasionally a long gap, so requests land at every point of the walk
         if ($urandom_range(99) < 5) gap = $urandom_range(LATENCY + 8);
         else while ($urandom_range(99) < send_idle_pct) gap++;
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_data  <= r;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      shadow.take_request(r);
   endtask

   // Drop valid and wait until every awaited response has arrived or the drain limit runs out.
   task automatic drain();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      while (shadow.awaited.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (4) @(posedge clock);
   endtask

   // Write the entry limit; only called with the block idle.
   task automatic write_limit(input logic [6:0] value);
      csr_wdata <= value;
      csr_we    <= 1'b1;
      @(posedge clock);
      csr_we    <= 1'b0;
      shadow.max_entries = value;
   endtask

   task automatic run_phase(input logic [6:0] limit, input int send_pct,
                            input int recv_pct, input bit pressure);
      drain();
      write_limit(limit);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      if (pressure) pressure_go = 1'b1;
      repeat (PHASE_ITEMS) send_request(next_request());
   endtask

   initial begin : stimulus
      logic [63:0] k0;
      logic [63:0] k1;
      logic [63:0] k2;
      logic [63:0] k3;
      string       tally;
      k0 = '0;
      k1 = '1;
      k2 = 64'hA5A5_A5A5_A5A5_A5A5;
      k3 = 64'h5A5A_5A5A_5A5A_5A5A;
      for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = {$urandom, $urandom};

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: entry life cycle, error paths and the unused command.
      send_request(make_req(CMD_RELEASE, k0, 32'h0));        // release of unknown key
      send_request(make_req(CMD_FILL,    k0, 32'h1234_5678)); // fill, nothing reserved
      send_request(make_req(CMD_ACQUIRE, k0, 32'h0));        // miss, reserve
      send_request(make_req(CMD_ACQUIRE, k0, 32'h0));        // busy while loading
      send_request(make_req(CMD_RELEASE, k0, 32'h0));        // release of loading key
      send_request(make_req(CMD_FILL,    k0, 32'hFFFF_FFFF));
      send_request(make_req(CMD_FILL,    k0, 32'h0));        // fill of a filled entry
      send_request(make_req(CMD_ACQUIRE, k0, 32'h0));        // hit, count 2
      send_request(make_req(CMD_RELEASE, k0, 32'h0));        // kept
      send_request(make_req(CMD_RELEASE, k0, 32'h0));        // evicted
      send_request(make_req(CMD_ACQUIRE, k1, 32'h0));
      send_request(make_req(CMD_FILL,    k1, 32'h0));
      send_request(make_req(CMD_UNUSED,  k1, 32'hFFFF_FFFF));
      send_request(make_req(CMD_RELEASE, k1, 32'h0));
      send_request(make_req(CMD_ACQUIRE, k2, 32'h0));
      send_request(make_req(CMD_FILL,    k2, 32'h5A5A_5A5A));
      // Limit zero: new keys full, held entries still hit.
      drain();
      write_limit(7'd0);
      send_request(make_req(CMD_ACQUIRE, k3, 32'h0));
      send_request(make_req(CMD_ACQUIRE, k2, 32'h0));
      // Limit one with one entry held: full until it is evicted.
      drain();
      write_limit(7'd1);
      send_request(make_req(CMD_ACQUIRE, k3, 32'h0));
      send_request(make_req(CMD_RELEASE, k2, 32'h0));
      send_request(make_req(CMD_RELEASE, k2, 32'h0));
      send_request(make_req(CMD_ACQUIRE, k3, 32'h0));
      send_request(make_req(CMD_ACQUIRE, k0, 32'h0));
      send_request(make_req(CMD_FILL,    k3, 32'hC3C3_3C3C));
      send_request(make_req(CMD_RELEASE, k3, 32'h0));

      // Random phases: limit, sender idle %, receiver stall %, hold-off.
      run_phase(7'd64,  0,  0,  1'b1);
      run_phase(7'd127, 67, 0,  1'b0);
      run_phase(7'd4,   0,  67, 1'b0);
      run_phase(7'd1,   22, 22, 1'b0);
      run_phase(7'd0,   0,  0,  1'b0);
      run_phase(7'($urandom_range(2, 63)), 67, 0, 1'b0);
      run_phase(7'd64,  0,  67, 1'b0);
      run_phase(7'd32,  22, 22, 1'b0);

      drain();
      // Catch any stray response after the last awaited one.
      repeat (2 * LATENCY) @(posedge clock);
      if (shadow.awaited.size() != 0)
         shadow.report($sformatf("%0d responses never arrived", shadow.awaited.size()));

      tally = $sformatf("%0d hit %0d miss %0d busy %0d full",
                        shadow.seen[STAT_HIT], shadow.seen[STAT_MISS],
                        shadow.seen[STAT_BUSY], shadow.seen[STAT_FULL]);
      tally = {tally, $sformatf(" %0d filled %0d kept %0d evicted %0d error",
                                shadow.seen[STAT_FILLED], shadow.seen[STAT_KEPT],
                                shadow.seen[STAT_EVICTED], shadow.seen[STAT_ERROR])};
      $display("Covered %0d requests: directed entry life cycle, then 8 random phases",
               shadow.requests_taken);
      $display("  limits 0..127, idle/stall mixes, a %0d-cycle receiver hold-off; %s",
               HOLD_CYCLES, tally);
      if (shadow.errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
